// File: hw/rtl/atrlp_pkg.sv
// ============================================================================
// atrlp_pkg
// Shared types and constants for the AT response line parser.
// ============================================================================
`default_nettype none

package atrlp_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CHAR_W  = 8;

    localparam logic [COUNT_W-1:0] POLL_LIMIT_RESET = 16'd10000;

    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] U32_MAX = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_POLL  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        RTYPE_NONE     = 2'd0,
        RTYPE_UNSIGNED = 2'd1,
        RTYPE_SIGNED   = 2'd2,
        RTYPE_FLOAT    = 2'd3
    } rtype_t;

    typedef enum logic [1:0]
    {
        STAT_WAIT      = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_TIMEOUT   = 2'd2,
        STAT_NOT_ARMED = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        LINE_CR     = 2'd0,
        LINE_LF     = 2'd1,
        LINE_GATHER = 2'd2,
        LINE_LF2    = 2'd3
    } line_phase_t;

    typedef enum logic [1:0]
    {
        NUM_SPACE  = 2'd0,
        NUM_SIGN   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_DONE   = 2'd3
    } num_phase_t;

    typedef struct packed
    {
        logic              kind;
        logic [1:0]        resp_type;
        logic              rx_valid;
        logic [CHAR_W-1:0] rx_byte;
    } item_t;

    typedef struct packed
    {
        status_t            status;
        logic               value_valid;
        logic [VALUE_W-1:0] value;
    } result_t;

    typedef struct packed
    {
        num_phase_t         phase;
        logic               neg;
        logic [VALUE_W-1:0] acc;
        logic               sat;
    } num_state_t;

    localparam num_state_t NUM_CLEAR = '{NUM_SPACE, 1'b0, '0, 1'b0};

    // Final value of a gathered field for the requested type
    function automatic logic [VALUE_W-1:0] final_value(logic [1:0] rtype, num_state_t num);
        logic [VALUE_W-1:0] negated;
        logic [VALUE_W-1:0] res;
        begin
            negated = VALUE_W'(0) - num.acc;
            if (rtype == RTYPE_UNSIGNED)
            begin
                if (num.sat)
                    res = U32_MAX;
                else
                    res = num.neg ? negated : num.acc;
            end
            else if (num.neg)
            begin
                res = (num.sat || (num.acc > S32_MIN)) ? S32_MIN : negated;
            end
            else
            begin
                res = (num.sat || (num.acc > S32_MAX)) ? S32_MAX : num.acc;
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/atrlp_in_stage.sv
// ============================================================================
// atrlp_in_stage
// Input request register; holds one request until the engine takes it.
// ============================================================================
`default_nettype none

module atrlp_in_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire atrlp_pkg::item_t in_item,
    input  wire logic            advance,
    output logic                 s1_valid,
    output atrlp_pkg::item_t     s1_item
);

    logic             valid_reg;
    logic             valid_next;
    atrlp_pkg::item_t item_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

// File: hw/rtl/atrlp_number.sv
// ============================================================================
// atrlp_number
// Decimal text accumulator: one character per request, strtoul style.
// ============================================================================
`default_nettype none

module atrlp_number
(
    input  wire logic [atrlp_pkg::CHAR_W-1:0] ch,
    input  wire atrlp_pkg::num_state_t        cur,
    output atrlp_pkg::num_state_t             nxt
);

    logic                                 is_digit;
    logic                                 is_space;
    logic [atrlp_pkg::VALUE_W-1:0]        digit;
    logic [atrlp_pkg::VALUE_W+3:0]        times_ten;
    atrlp_pkg::num_state_t                with_digit;

    always_comb
    begin
        is_digit = (ch >= atrlp_pkg::CHAR_ZERO) && (ch <= atrlp_pkg::CHAR_NINE);
        is_space = (ch == atrlp_pkg::CHAR_SPACE) ||
                   ((ch >= atrlp_pkg::CHAR_TAB) && (ch <= atrlp_pkg::CHAR_CR));
        digit    = atrlp_pkg::VALUE_W'(ch - atrlp_pkg::CHAR_ZERO);
        // acc*10 + d, four guard bits catch overflow
        times_ten = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1)
                  + {4'b0, digit};

        with_digit       = cur;
        with_digit.phase = atrlp_pkg::NUM_DIGITS;
        if (cur.sat || (times_ten[atrlp_pkg::VALUE_W+3:atrlp_pkg::VALUE_W] != 4'd0))
            with_digit.sat = 1'b1;
        else
            with_digit.acc = times_ten[atrlp_pkg::VALUE_W-1:0];

        nxt = cur;
        case (cur.phase)
            atrlp_pkg::NUM_SPACE:
            begin
                if (is_space)
                    nxt = cur;
                else if ((ch == atrlp_pkg::CHAR_PLUS) || (ch == atrlp_pkg::CHAR_MINUS))
                begin
                    nxt.neg   = (ch == atrlp_pkg::CHAR_MINUS);
                    nxt.phase = atrlp_pkg::NUM_SIGN;
                end
                else if (is_digit)
                    nxt = with_digit;
                else
                    nxt.phase = atrlp_pkg::NUM_DONE;
            end
            atrlp_pkg::NUM_SIGN, atrlp_pkg::NUM_DIGITS:
            begin
                if (is_digit)
                    nxt = with_digit;
                else
                    nxt.phase = atrlp_pkg::NUM_DONE;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/atrlp_engine.sv
// ============================================================================
// atrlp_engine
// Line framing, poll timeout, number state; one request per cycle on fire.
// ============================================================================
`default_nettype none

module atrlp_engine
#(
    parameter int unsigned FIELD_CHARS = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [atrlp_pkg::COUNT_W-1:0] cfg_data,
    input  wire logic                          fire,
    input  wire atrlp_pkg::item_t              item,
    output atrlp_pkg::result_t                 result
);

    localparam logic [atrlp_pkg::CHAR_W-1:0] FIELD_LIMIT = atrlp_pkg::CHAR_W'(FIELD_CHARS);

    logic [atrlp_pkg::COUNT_W-1:0] poll_limit_reg;
    logic                          armed_reg;
    logic                          armed_next;
    atrlp_pkg::line_phase_t        line_reg;
    atrlp_pkg::line_phase_t        line_next;
    logic [1:0]                    type_reg;
    logic [1:0]                    type_next;
    logic [atrlp_pkg::COUNT_W-1:0] poll_reg;
    logic [atrlp_pkg::COUNT_W-1:0] poll_next;
    logic [atrlp_pkg::CHAR_W-1:0]  chars_reg;
    logic [atrlp_pkg::CHAR_W-1:0]  chars_next;
    logic [atrlp_pkg::CHAR_W-1:0]  chars_inc;
    atrlp_pkg::num_state_t         num_reg;
    atrlp_pkg::num_state_t         num_next;
    atrlp_pkg::num_state_t         num_fed;
    logic                          found;

    atrlp_number u_number
    (
        .ch  (item.rx_byte),
        .cur (num_reg),
        .nxt (num_fed)
    );

    always_comb
    begin
        armed_next = armed_reg;
        line_next  = line_reg;
        type_next  = type_reg;
        poll_next  = poll_reg;
        chars_next = chars_reg;
        num_next   = num_reg;
        chars_inc  = chars_reg + atrlp_pkg::CHAR_W'(1);
        found      = 1'b0;
        result     = '{atrlp_pkg::STAT_WAIT, 1'b0, '0};

        if (item.kind == atrlp_pkg::KIND_START)
        begin
            armed_next = 1'b1;
            type_next  = item.resp_type;
            line_next  = atrlp_pkg::LINE_CR;
            poll_next  = '0;
            chars_next = '0;
            num_next   = atrlp_pkg::NUM_CLEAR;
        end
        else if (!armed_reg)
        begin
            result.status = atrlp_pkg::STAT_NOT_ARMED;
        end
        else
        begin
            if (item.rx_valid)
            begin
                case (line_reg)
                    atrlp_pkg::LINE_CR:
                    begin
                        if (item.rx_byte == atrlp_pkg::CHAR_CR)
                            line_next = atrlp_pkg::LINE_LF;
                    end
                    atrlp_pkg::LINE_LF:
                    begin
                        if (item.rx_byte == atrlp_pkg::CHAR_LF)
                        begin
                            line_next  = atrlp_pkg::LINE_GATHER;
                            chars_next = '0;
                            num_next   = atrlp_pkg::NUM_CLEAR;
                        end
                    end
                    atrlp_pkg::LINE_GATHER:
                    begin
                        if (item.rx_byte == atrlp_pkg::CHAR_CR)
                            line_next = atrlp_pkg::LINE_LF2;
                        else
                        begin
                            num_next   = num_fed;
                            chars_next = chars_inc;
                            // field full: restart the line search
                            if (chars_inc >= FIELD_LIMIT)
                                line_next = atrlp_pkg::LINE_CR;
                        end
                    end
                    default:
                    begin
                        found = (item.rx_byte == atrlp_pkg::CHAR_LF);
                    end
                endcase
            end

            if (poll_reg >= poll_limit_reg)
            begin
                result.status = atrlp_pkg::STAT_TIMEOUT;
                armed_next    = 1'b0;
            end
            else
            begin
                poll_next = poll_reg + atrlp_pkg::COUNT_W'(1);
                if (found)
                begin
                    result.status = atrlp_pkg::STAT_FOUND;
                    armed_next    = 1'b0;
                    if ((type_reg == atrlp_pkg::RTYPE_UNSIGNED) ||
                        (type_reg == atrlp_pkg::RTYPE_SIGNED))
                    begin
                        result.value_valid = 1'b1;
                        result.value       = atrlp_pkg::final_value(type_reg, num_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= atrlp_pkg::POLL_LIMIT_RESET;
            armed_reg      <= 1'b0;
            line_reg       <= atrlp_pkg::LINE_CR;
            type_reg       <= atrlp_pkg::RTYPE_NONE;
            poll_reg       <= '0;
            chars_reg      <= '0;
            num_reg        <= atrlp_pkg::NUM_CLEAR;
        end
        else
        begin
            if (cfg_we)
                poll_limit_reg <= cfg_data;
            if (fire)
            begin
                armed_reg <= armed_next;
                line_reg  <= line_next;
                type_reg  <= type_next;
                poll_reg  <= poll_next;
                chars_reg <= chars_next;
                num_reg   <= num_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/at_response_line_parser_core.sv
// Result path: input register, then parse logic into the result register.
// Throughput: one request per cycle unless a stalled result holds the flow;
// a new request is taken into the input register while a result waits.
// Reset: asynchronous, active low; parser disarmed, poll_limit returns to 10000.
// ============================================================================
// at_response_line_parser_core
// AT response line parser: CR/LF framing, decimal field parse, poll timeout.
// ============================================================================
`default_nettype none

module at_response_line_parser_core
#(
    parameter int unsigned FIELD_CHARS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [1:0]  resp_type,
    input  wire logic        rx_valid,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             value_valid,
    output logic [31:0]      value
);

    atrlp_pkg::item_t   in_item;
    atrlp_pkg::item_t   s1_item;
    atrlp_pkg::result_t eng_result;
    atrlp_pkg::result_t result_reg;
    logic               s1_valid;
    logic               advance;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign cfg_ready = 1'b1;

    assign in_item = '{kind, resp_type, rx_valid, rx_byte};
    assign advance = s1_valid && (!out_valid_reg || out_ready);

    atrlp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    atrlp_engine #(.FIELD_CHARS(FIELD_CHARS)) u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (advance),
        .item     (s1_item),
        .result   (eng_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= eng_result;
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign value_valid = result_reg.value_valid;
    assign value       = result_reg.value;

endmodule

`default_nettype wire

// File: hw/rtl/atrlp_checker.sv
// ============================================================================
// atrlp_checker
// Port-level checks on the parser's result channel.
// ============================================================================
`default_nettype none

module atrlp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic        value_valid,
    input wire logic [31:0] value
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_valid)
        && $stable(value))
        else $error("result changed while stalled");

    a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_valid |-> status == atrlp_pkg::STAT_FOUND)
        else $error("value flagged on a non-found status");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !value_valid |-> value == 32'd0)
        else $error("value not zero without value_valid");

    // nothing leaves without a request having entered earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(in_valid && in_ready, 3)
        || $past(out_valid, 2))
        else $error("result without a request");

endmodule

bind at_response_line_parser_core atrlp_checker u_atrlp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .value_valid (value_valid),
    .value       (value)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the AT response line parser core.
// Start and poll requests go in over a valid/ready channel, with random gaps
// on the request side and random stalls on the reply side. A scoreboard class
// models the parser (framing, decimal parse, poll timeout) and checks every
// reply in order. The run steps through several poll_limit settings.
// ============================================================================

module tb;

    localparam int unsigned FIELD_LEN   = 32;
    localparam int unsigned STALL_LIMIT = 1000;

    class reply_board;
        logic [15:0]            poll_limit;
        bit                     armed;
        atrlp_pkg::line_phase_t line;
        atrlp_pkg::rtype_t      wanted;
        logic [15:0]            polls;
        logic [7:0]             chars;
        atrlp_pkg::num_phase_t  nphase;
        bit                     neg;
        logic [31:0]            acc;
        bit                     sat;
        atrlp_pkg::result_t     replies_due[$];
        int unsigned            errors;
        int unsigned            requests;
        int unsigned            replies;
        int unsigned            found;
        int unsigned            timeouts;

        function new();
            poll_limit = atrlp_pkg::POLL_LIMIT_RESET;
            armed      = 1'b0;
            line       = atrlp_pkg::LINE_CR;
            wanted     = atrlp_pkg::RTYPE_NONE;
            polls      = '0;
            chars      = '0;
            clear_number();
        endfunction

        function void clear_number();
            nphase = atrlp_pkg::NUM_SPACE;
            neg    = 1'b0;
            acc    = '0;
            sat    = 1'b0;
        endfunction

        function void take_digit(logic [3:0] d);
            longint unsigned nxt;
            nxt = 64'(acc) * 64'd10 + 64'(d);
            if (sat || nxt > 64'hFFFF_FFFF)
                sat = 1'b1;
            else
                acc = nxt[31:0];
            nphase = atrlp_pkg::NUM_DIGITS;
        endfunction

        function void feed_char(logic [7:0] b);
            bit is_digit;
            bit is_space;
            is_digit = (b >= atrlp_pkg::CHAR_ZERO) && (b <= atrlp_pkg::CHAR_NINE);
            is_space = (b == atrlp_pkg::CHAR_SPACE) ||
                       ((b >= atrlp_pkg::CHAR_TAB) && (b <= atrlp_pkg::CHAR_CR));
            case (nphase)
                atrlp_pkg::NUM_SPACE:
                begin
                    if (!is_space)
                    begin
                        if (b == atrlp_pkg::CHAR_PLUS || b == atrlp_pkg::CHAR_MINUS)
                        begin
                            neg    = (b == atrlp_pkg::CHAR_MINUS);
                            nphase = atrlp_pkg::NUM_SIGN;
                        end
                        else if (is_digit)
                            take_digit(4'(b - atrlp_pkg::CHAR_ZERO));
                        else
                            nphase = atrlp_pkg::NUM_DONE;
                    end
                end
                atrlp_pkg::NUM_SIGN, atrlp_pkg::NUM_DIGITS:
                begin
                    if (is_digit)
                        take_digit(4'(b - atrlp_pkg::CHAR_ZERO));
                    else
                        nphase = atrlp_pkg::NUM_DONE;
                end
                default:
                begin
                end
            endcase
        endfunction

        function logic [31:0] field_value();
            logic [31:0] v;
            if (wanted == atrlp_pkg::RTYPE_UNSIGNED)
                v = sat ? atrlp_pkg::U32_MAX : (neg ? 32'd0 - acc : acc);
            else if (neg)
                v = (sat || acc > atrlp_pkg::S32_MIN) ? atrlp_pkg::S32_MIN : 32'd0 - acc;
            else
                v = (sat || acc > atrlp_pkg::S32_MAX) ? atrlp_pkg::S32_MAX : acc;
            return v;
        endfunction

        function void note_request(logic k, logic [1:0] rt, logic rv, logic [7:0] b);
            atrlp_pkg::result_t r;
            bit                 done;
            r.status      = atrlp_pkg::STAT_WAIT;
            r.value_valid = 1'b0;
            r.value       = '0;
            done          = 1'b0;
            requests++;
            if (k == atrlp_pkg::KIND_START)
            begin
                armed  = 1'b1;
                wanted = atrlp_pkg::rtype_t'(rt);
                line   = atrlp_pkg::LINE_CR;
                polls  = '0;
                chars  = '0;
                clear_number();
            end
            else if (!armed)
                r.status = atrlp_pkg::STAT_NOT_ARMED;
            else
            begin
                if (rv)
                begin
                    case (line)
                        atrlp_pkg::LINE_CR:
                        begin
                            if (b == atrlp_pkg::CHAR_CR)
                                line = atrlp_pkg::LINE_LF;
                        end
                        atrlp_pkg::LINE_LF:
                        begin
                            if (b == atrlp_pkg::CHAR_LF)
                            begin
                                line  = atrlp_pkg::LINE_GATHER;
                                chars = '0;
                                clear_number();
                            end
                        end
                        atrlp_pkg::LINE_GATHER:
                        begin
                            if (b == atrlp_pkg::CHAR_CR)
                                line = atrlp_pkg::LINE_LF2;
                            else
                            begin
                                feed_char(b);
                                chars = chars + 8'd1;
                                // field full: hunt for a fresh CR
                                if (chars >= FIELD_LEN)
                                    line = atrlp_pkg::LINE_CR;
                            end
                        end
                        default:
                            done = (b == atrlp_pkg::CHAR_LF);
                    endcase
                end
                // timeout wins over a completion on the same poll
                if (polls >= poll_limit)
                begin
                    r.status = atrlp_pkg::STAT_TIMEOUT;
                    armed    = 1'b0;
                end
                else
                begin
                    polls = polls + 16'd1;
                    if (done)
                    begin
                        r.status = atrlp_pkg::STAT_FOUND;
                        armed    = 1'b0;
                        if (wanted == atrlp_pkg::RTYPE_UNSIGNED ||
                            wanted == atrlp_pkg::RTYPE_SIGNED)
                        begin
                            r.value_valid = 1'b1;
                            r.value       = field_value();
                        end
                    end
                end
            end
            replies_due.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_reply(logic [1:0] st, logic vv, logic [31:0] v);
            atrlp_pkg::result_t e;
            replies++;
            if (st == atrlp_pkg::STAT_FOUND)
                found++;
            if (st == atrlp_pkg::STAT_TIMEOUT)
                timeouts++;
            if (replies_due.size() == 0)
            begin
                report($sformatf("reply %0d arrived with nothing due", replies));
                return;
            end
            e = replies_due.pop_front();
            if (st != e.status)
                report($sformatf("reply %0d status %0d, want %0d", replies, st, e.status));
            if (vv != e.value_valid)
                report($sformatf("reply %0d value_valid %0d, want %0d",
                                 replies, vv, e.value_valid));
            if (v != e.value)
                report($sformatf("reply %0d value %08h, want %08h", replies, v, e.value));
        endtask

        task close();
            if (replies_due.size() != 0)
                report($sformatf("%0d replies never arrived", replies_due.size()));
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        kind          = 1'b0;
    logic [1:0]  resp_type     = '0;
    logic        rx_valid      = 1'b0;
    logic [7:0]  rx_byte       = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [1:0]  status;
    logic        value_valid;
    logic [31:0] value;

    bit          gaps_on      = 1'b1;
    int unsigned sent         = 0;
    int unsigned settings     = 0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  line_buf[$];
    reply_board  board;

    at_response_line_parser_core
    #(
        .FIELD_CHARS   (FIELD_LEN)
    )
    i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .resp_type     (resp_type),
        .rx_valid      (rx_valid),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .value_valid   (value_valid),
        .value         (value)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // inputs only move at rising edges, so the falling edge sees what the next edge takes
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_request(kind, resp_type, rx_valid, rx_byte);
            if (out_valid && out_ready)
                board.check_reply(status, value_valid, value);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic pause_sender(int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(logic k, logic [1:0] rt, logic rv, logic [7:0] b);
        if (gaps_on && $urandom_range(0, 9) == 0)
            pause_sender($urandom_range(1, 16));
        in_valid  <= 1'b1;
        kind      <= k;
        resp_type <= rt;
        rx_valid  <= rv;
        rx_byte   <= b;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        sent++;
    endtask

    task automatic arm(logic [1:0] rt);
        send_request(atrlp_pkg::KIND_START, rt, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
    endtask

    task automatic poll(logic [7:0] b);
        if ($urandom_range(0, 7) == 0)
            send_request(atrlp_pkg::KIND_POLL, 2'($urandom_range(0, 3)), 1'b0,
                         8'($urandom_range(0, 255)));
        send_request(atrlp_pkg::KIND_POLL, 2'($urandom_range(0, 3)), 1'b1, b);
    endtask

    task automatic flush_line();
        while (line_buf.size() != 0)
            poll(line_buf.pop_front());
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic push_crlf();
        line_buf.push_back(atrlp_pkg::CHAR_CR);
        line_buf.push_back(atrlp_pkg::CHAR_LF);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        board.poll_limit = v;
        settings++;
    endtask

    function automatic logic [1:0] pick_type();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return atrlp_pkg::RTYPE_UNSIGNED;
        if (r < 8)
            return atrlp_pkg::RTYPE_SIGNED;
        return (r == 8) ? atrlp_pkg::RTYPE_NONE : atrlp_pkg::RTYPE_FLOAT;
    endfunction

    function automatic logic [7:0] space_byte();
        if ($urandom_range(0, 1) == 0)
            return atrlp_pkg::CHAR_SPACE;
        return 8'(atrlp_pkg::CHAR_TAB + $urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] noise_byte();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return atrlp_pkg::CHAR_CR;
        if (r < 8)
            return atrlp_pkg::CHAR_LF;
        if (r < 13)
            return 8'(atrlp_pkg::CHAR_ZERO + $urandom_range(0, 9));
        if (r == 13)
            return atrlp_pkg::CHAR_PLUS;
        if (r == 14)
            return atrlp_pkg::CHAR_MINUS;
        if (r < 17)
            return space_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_response();
        int unsigned     pick;
        longint unsigned mag;
        logic [7:0]      junk;
        arm(pick_type());
        repeat ($urandom_range(0, 3)) line_buf.push_back(noise_byte());
        push_crlf();
        repeat ($urandom_range(0, 2)) line_buf.push_back(space_byte());
        pick = $urandom_range(0, 3);
        if (pick == 0)
            line_buf.push_back(atrlp_pkg::CHAR_PLUS);
        else if (pick == 1)
            line_buf.push_back(atrlp_pkg::CHAR_MINUS);
        repeat ($urandom_range(0, 2)) line_buf.push_back(atrlp_pkg::CHAR_ZERO);
        pick = $urandom_range(0, 9);
        case (pick)
            0: mag = 0;
            1: mag = 64'hFFFF_FFFF;
            2: mag = 64'h1_0000_0000;
            3: mag = 64'h7FFF_FFFF;
            4: mag = 64'h8000_0000;
            5: mag = 64'h8000_0001;
            6: mag = $urandom;
            7: mag = $urandom_range(0, 999);
            default: mag = {$urandom, $urandom} % 64'd1000000000000;
        endcase
        if (pick != 9)
            push_text($sformatf("%0d", mag));
        if ($urandom_range(0, 3) == 0)
        begin
            junk = 8'($urandom_range(0, 255));
            line_buf.push_back((junk == atrlp_pkg::CHAR_CR) ? atrlp_pkg::CHAR_SPACE : junk);
        end
        push_crlf();
        flush_line();
    endtask

    task automatic broken_sequence();
        if ($urandom_range(0, 2) != 0)
            arm(pick_type());
        repeat ($urandom_range(1, 40))
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                flush_line();
                arm(pick_type());
            end
            line_buf.push_back(noise_byte());
        end
        flush_line();
    endtask

    task automatic long_field();
        arm(pick_type());
        push_crlf();
        repeat ($urandom_range(FIELD_LEN - 2, FIELD_LEN + 8))
        begin
            if ($urandom_range(0, 4) == 0)
                line_buf.push_back(space_byte());
            else
                line_buf.push_back(8'(atrlp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        push_crlf();
        flush_line();
    endtask

    task automatic run_phase(int unsigned budget);
        int unsigned goal;
        int unsigned pick;
        goal = sent + budget;
        while (sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                random_response();
            else if (pick < 85)
                broken_sequence();
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 6)) poll(noise_byte());
                flush_line();
            end
            else
                long_field();
        end
    endtask

    initial
    begin
        logic [15:0] limits[8];
        board = new();
        limits = '{16'd65535, 16'd0, 16'd1, 16'd7, 16'd24,
                   16'($urandom_range(8, 65535)), 16'd3, atrlp_pkg::POLL_LIMIT_RESET};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: unarmed poll, negated unsigned, empty field, float, rearm
        send_request(atrlp_pkg::KIND_POLL, atrlp_pkg::RTYPE_FLOAT, 1'b1, 8'hFF);
        arm(atrlp_pkg::RTYPE_UNSIGNED);
        push_crlf();
        push_text("-7");
        push_crlf();
        flush_line();
        arm(atrlp_pkg::RTYPE_SIGNED);
        push_crlf();
        push_crlf();
        flush_line();
        arm(atrlp_pkg::RTYPE_FLOAT);
        send_request(atrlp_pkg::KIND_POLL, atrlp_pkg::RTYPE_NONE, 1'b0, 8'h00);
        push_crlf();
        push_text("5");
        push_crlf();
        flush_line();
        arm(atrlp_pkg::RTYPE_NONE);
        line_buf.push_back(atrlp_pkg::CHAR_CR);
        flush_line();
        arm(atrlp_pkg::RTYPE_SIGNED);
        poll(atrlp_pkg::CHAR_CR);
        drain();

        foreach (limits[i])
        begin
            write_limit(limits[i]);
            if (i == $size(limits) - 1)
                gaps_on = 1'b0;
            run_phase((limits[i] < 16'd8) ? 40 : 115);
            drain();
        end

        board.close();
        $display("Covered %0d requests and %0d replies over %0d poll_limit settings,",
                 board.requests, board.replies, settings);
        $display("with %0d responses found and %0d timeouts.", board.found, board.timeouts);
        if (board.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/atrlp_pkg.sv
hw/rtl/atrlp_in_stage.sv
hw/rtl/atrlp_number.sv
hw/rtl/atrlp_engine.sv
hw/rtl/at_response_line_parser_core.sv
hw/rtl/atrlp_checker.sv
tb/tb.sv
